>>> src/tcik_pkg.sv
// Shared types and constants of the two-cable planar inverse kinematics unit.
// No dependencies.
package tcik_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_A_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_A_Z  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_B_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_B_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIRE_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_SCALE   = 3'd5;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] motor_a_position;
        logic signed [31:0] motor_a_velocity;
        logic signed [31:0] motor_b_position;
        logic signed [31:0] motor_b_velocity;
        logic               at_anchor_a;
        logic               at_anchor_b;
        logic               saturated;
    } t_out;

    // Queued job: offsets to both anchors plus the velocity.
    typedef struct packed {
        logic signed [32:0] dax;
        logic signed [32:0] daz;
        logic signed [32:0] dbx;
        logic signed [32:0] dbz;
        logic signed [31:0] vx;
        logic signed [31:0] vz;
    } t_job;

    // One motor's result.
    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               at;
        logic               sat;
    } t_motor;

endpackage

>>> src/two_cable_planar_inverse_kinematics_unit.sv
// Top level of the two-cable planar inverse kinematics unit: config registers,
// front end queue and two motor lanes. Depends on tcik_pkg, tcik_front, tcik_lane.
//
//  channel  direction  handshake              payload
//  in       input      i_valid / o_stall      i_data  (t_in)
//  out      output     o_valid / i_stall      o_data  (t_out)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled. The beat
// lands in the queue at its accepting edge, then passes 71 lane
// stages (two for squares and sums, 33 root stages, three for scaling,
// 32 divider stages, one clip).
// Reset is synchronous, active low, and clears control state and the config registers only.
// An output stall freezes both lanes; the four-entry queue keeps taking
// beats until it fills, then raises o_stall.
module two_cable_planar_inverse_kinematics_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  tcik_pkg::t_in                      i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output tcik_pkg::t_out                     o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcik_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import tcik_pkg::*;

    // configuration registers
    logic signed [31:0] r_anchor_a_x, r_anchor_a_z, r_anchor_b_x, r_anchor_b_z;
    logic [30:0]        r_wire_length, r_rev_scale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_a_x  <= '0;
            r_anchor_a_z  <= '0;
            r_anchor_b_x  <= '0;
            r_anchor_b_z  <= '0;
            r_wire_length <= '0;
            r_rev_scale   <= 31'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ANCHOR_A_X:  r_anchor_a_x  <= i_cfg_data;
                CFG_ANCHOR_A_Z:  r_anchor_a_z  <= i_cfg_data;
                CFG_ANCHOR_B_X:  r_anchor_b_x  <= i_cfg_data;
                CFG_ANCHOR_B_Z:  r_anchor_b_z  <= i_cfg_data;
                CFG_WIRE_LENGTH: r_wire_length <= i_cfg_data[30:0];
                CFG_REV_SCALE:   r_rev_scale   <= i_cfg_data[30:0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    // front end
    logic head_valid, en, va, vb;
    t_job head;
    t_motor res_a, res_b;

    // lanes advance unless a finished result is held by the sink
    assign en = !(o_valid && i_stall);

    tcik_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .i_anchor_a_x (r_anchor_a_x),
        .i_anchor_a_z (r_anchor_a_z),
        .i_anchor_b_x (r_anchor_b_x),
        .i_anchor_b_z (r_anchor_b_z),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (en)
    );

    tcik_lane u_lane_a (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (head_valid),
        .i_dx          (head.dax),
        .i_dz          (head.daz),
        .i_vx          (head.vx),
        .i_vz          (head.vz),
        .i_wire_length (r_wire_length),
        .i_rev_scale   (r_rev_scale),
        .o_valid       (va),
        .o_res         (res_a)
    );

    tcik_lane u_lane_b (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (head_valid),
        .i_dx          (head.dbx),
        .i_dz          (head.dbz),
        .i_vx          (head.vx),
        .i_vz          (head.vz),
        .i_wire_length (r_wire_length),
        .i_rev_scale   (r_rev_scale),
        .o_valid       (vb),
        .o_res         (res_b)
    );

    // lanes run in lockstep; final lane stage is the output register
    assign o_valid = va && vb;

    always_comb begin
        o_data.motor_a_position = res_a.pos;
        o_data.motor_a_velocity = res_a.vel;
        o_data.motor_b_position = res_b.pos;
        o_data.motor_b_velocity = res_b.vel;
        o_data.at_anchor_a      = res_a.at;
        o_data.at_anchor_b      = res_b.at;
        o_data.saturated        = res_a.sat || res_b.sat;
    end

endmodule

>>> src/tcik_front.sv
// Front end: accepts input beats, forms anchor offsets, queues jobs.
// Depends on tcik_pkg.
module tcik_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tcik_pkg::t_in       i_data,
    input  logic signed [31:0]  i_anchor_a_x,
    input  logic signed [31:0]  i_anchor_a_z,
    input  logic signed [31:0]  i_anchor_b_x,
    input  logic signed [31:0]  i_anchor_b_z,
    output logic                o_head_valid,
    output tcik_pkg::t_job      o_head,
    input  logic                i_pop
);
    import tcik_pkg::*;

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    t_job            r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop;
    t_job            job;

    assign o_stall      = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        job.dax = {i_data.pos_x[31], i_data.pos_x} - {i_anchor_a_x[31], i_anchor_a_x};
        job.daz = {i_data.pos_z[31], i_data.pos_z} - {i_anchor_a_z[31], i_anchor_a_z};
        job.dbx = {i_data.pos_x[31], i_data.pos_x} - {i_anchor_b_x[31], i_anchor_b_x};
        job.dbz = {i_data.pos_z[31], i_data.pos_z} - {i_anchor_b_z[31], i_anchor_b_z};
        job.vx  = i_data.vel_x;
        job.vz  = i_data.vel_z;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (!push && pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

>>> src/tcik_lane.sv
// Back end lane for one motor: squares, pipelined square root, products,
// pipelined restoring divider, saturation. Depends on tcik_pkg.
module tcik_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [32:0]  i_dx,
    input  logic signed [32:0]  i_dz,
    input  logic signed [31:0]  i_vx,
    input  logic signed [31:0]  i_vz,
    input  logic [30:0]         i_wire_length,
    input  logic [30:0]         i_rev_scale,
    output logic                o_valid,
    output tcik_pkg::t_motor    o_res
);
    import tcik_pkg::*;

    localparam int unsigned SQ_STEPS  = 33;
    localparam int unsigned DIV_STEPS = 32;

    typedef struct packed {
        logic [48:0]        d;
        logic               lz;
        logic               nneg;
        logic signed [31:0] pos;
        logic               psat;
        logic               ovf;
    } t_carry;

    // stage 1: squares and products
    logic               r1_v;
    logic [65:0]        r1_sqx, r1_sqz;
    logic signed [64:0] r1_px, r1_pz;
    logic [32:0]        mdx, mdz;

    assign mdx = i_dx[32] ? 33'(-i_dx) : 33'(i_dx);
    assign mdz = i_dz[32] ? 33'(-i_dz) : 33'(i_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (i_en) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sqx <= mdx * mdx;
            r1_sqz <= mdz * mdz;
            r1_px  <= i_vx * i_dx;
            r1_pz  <= i_vz * i_dz;
        end
    end

    // stage 2: sums; start of root pipeline at index 0
    logic               r_sv   [SQ_STEPS+1];
    logic [65:0]        r_srad [SQ_STEPS+1];
    logic [35:0]        r_srem [SQ_STEPS+1];
    logic [32:0]        r_sq   [SQ_STEPS+1];
    logic signed [65:0] r_sn   [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (i_en) r_sv[0] <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_srad[0] <= r1_sqx + r1_sqz;
            r_srem[0] <= '0;
            r_sq[0]   <= '0;
            r_sn[0]   <= 66'(r1_px) + 66'(r1_pz);
        end
    end

    // two radicand bits per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [35:0] remsh, trial;
        assign remsh = {r_srem[k][33:0], r_srad[k][65:64]};
        assign trial = {1'b0, r_sq[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else if (i_en) r_sv[k+1] <= r_sv[k];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srad[k+1] <= {r_srad[k][63:0], 2'b00};
                r_sn[k+1]   <= r_sn[k];
                if (remsh >= trial) begin
                    r_srem[k+1] <= remsh - trial;
                    r_sq[k+1]   <= {r_sq[k][31:0], 1'b1};
                end else begin
                    r_srem[k+1] <= remsh;
                    r_sq[k+1]   <= {r_sq[k][31:0], 1'b0};
                end
            end
        end
    end

    // stage A: length difference and magnitudes
    logic               ra_v, ra_neg, ra_nneg;
    logic [33:0]        ra_dmag;
    logic [64:0]        ra_nmag;
    logic [32:0]        ra_len;
    logic signed [34:0] diff;
    logic signed [65:0] nval;

    assign diff = $signed({4'b0, i_wire_length}) - $signed({2'b0, r_sq[SQ_STEPS]});
    assign nval = r_sn[SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_v <= 1'b0;
        else if (i_en) ra_v <= r_sv[SQ_STEPS];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_neg  <= diff[34];
            ra_dmag <= diff[34] ? 34'(-diff) : 34'(diff);
            ra_nneg <= nval[65];
            ra_nmag <= nval[65] ? 65'(-nval) : 65'(nval);
            ra_len  <= r_sq[SQ_STEPS];
        end
    end

    // stage B: scale products, wide product split in two
    logic        rb_v, rb_neg, rb_nneg;
    logic [64:0] rb_pp;
    logic [63:0] rb_mlo;
    logic [62:0] rb_mhi;
    logic [32:0] rb_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v <= 1'b0;
        else if (i_en) rb_v <= ra_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rb_pp   <= ra_dmag * i_rev_scale;
            rb_mlo  <= ra_nmag[32:0] * i_rev_scale;
            rb_mhi  <= ra_nmag[64:33] * i_rev_scale;
            rb_neg  <= ra_neg;
            rb_nneg <= ra_nneg;
            rb_len  <= ra_len;
        end
    end

    // stage C: combine, clip position, quotient overflow check
    logic        r_dv   [DIV_STEPS+1];
    t_carry      r_dc   [DIV_STEPS+1];
    logic [49:0] r_drem [DIV_STEPS+1];
    logic [31:0] r_dlow [DIV_STEPS+1];
    logic [31:0] r_dq   [DIV_STEPS+1];

    logic [95:0] m;
    logic [48:0] dd, pmag;
    logic [31:0] plim;
    logic        psat;
    logic [31:0] pval;
    t_carry      cc;

    always_comb begin
        m    = {32'b0, rb_mlo} + {rb_mhi, 33'b0};
        dd   = {rb_len, 16'b0};
        pmag = rb_pp[64:16];
        plim = rb_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        psat = pmag > {17'b0, plim};
        pval = psat ? plim : pmag[31:0];
        cc.d    = dd;
        cc.lz   = (rb_len == '0);
        cc.nneg = rb_nneg;
        cc.pos  = rb_neg ? -pval : pval;
        cc.psat = psat;
        cc.ovf  = m[95:32] >= {15'b0, dd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (i_en) r_dv[0] <= rb_v;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dc[0]   <= cc;
            r_drem[0] <= m[81:32];
            r_dlow[0] <= m[31:0];
            r_dq[0]   <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [49:0] remsh;
        assign remsh = {r_drem[j][48:0], r_dlow[j][31]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j+1] <= 1'b0;
            else if (i_en) r_dv[j+1] <= r_dv[j];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dc[j+1]   <= r_dc[j];
                r_dlow[j+1] <= {r_dlow[j][30:0], 1'b0};
                if (remsh >= {1'b0, r_dc[j].d}) begin
                    r_drem[j+1] <= remsh - {1'b0, r_dc[j].d};
                    r_dq[j+1]   <= {r_dq[j][30:0], 1'b1};
                end else begin
                    r_drem[j+1] <= remsh;
                    r_dq[j+1]   <= {r_dq[j][30:0], 1'b0};
                end
            end
        end
    end

    // final: clip velocity; point on anchor forces zero
    t_carry      fc;
    logic [31:0] q, vlim, vmag;
    logic        vsat;
    t_motor      res;

    always_comb begin
        fc   = r_dc[DIV_STEPS];
        q    = r_dq[DIV_STEPS];
        vlim = fc.nneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        vsat = !fc.lz && (fc.ovf || q > vlim);
        vmag = vsat ? vlim : q;
        res.pos = fc.pos;
        res.vel = fc.lz ? 32'sd0 : (fc.nneg ? -vmag : vmag);
        res.at  = fc.lz;
        res.sat = fc.psat || vsat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_dv[DIV_STEPS];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) o_res <= res;
    end

endmodule

>>> test/tb.sv
// Testbench for two_cable_planar_inverse_kinematics_unit: random and directed
// setpoints checked against an exact fixed-point predictor kept in this file.
// Depends on tcik_pkg and the unit's RTL.
module tb;
    import tcik_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in                  i_data;
    logic                 o_valid;
    logic                 i_stall;
    t_out                 o_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    two_cable_planar_inverse_kinematics_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the unit's registers, updated on each accepted write.
    logic signed [31:0] anc_ax = '0, anc_az = '0, anc_bx = '0, anc_bz = '0;
    logic [30:0]        wire_len = '0;
    logic [30:0]        revs = 31'd65536;

    t_in  setpoints[$];
    t_out motor_cmds[$];
    int   errors = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   cyc = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Clip a magnitude with sign to 32-bit two's complement.
    function automatic logic [31:0] clip32(input logic [127:0] m, input logic neg,
                                           inout logic sat);
        logic [127:0] lim;
        logic [31:0]  v;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (m > lim) begin
            sat = 1'b1;
            v = lim[31:0];
        end else begin
            v = m[31:0];
        end
        return neg ? -v : v;
    endfunction

    // One pulley: wire length, motor angle and motor rate.
    function automatic void solve_pulley(input logic signed [32:0] dx,
                                         input logic signed [32:0] dz,
                                         input logic signed [31:0] vx,
                                         input logic signed [31:0] vz,
                                         output logic [31:0] pos, output logic [31:0] vel,
                                         output logic at, inout logic sat);
        logic signed [69:0] ex, ez, wx, wz, n;
        logic [67:0]        sq, r, c;
        logic [33:0]        len;
        logic signed [40:0] diff;
        logic [40:0]        dmag;
        logic [127:0]       prod, nmag;
        logic               neg;
        ex = dx;
        ez = dz;
        wx = vx;
        wz = vz;
        sq = 68'(ex * ex + ez * ez);
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (68'd1 << b);
            if (c * c <= sq) r = c;
        end
        len = r[33:0];
        diff = $signed({10'd0, wire_len}) - $signed({7'd0, len});
        dmag = diff < 0 ? 41'(-diff) : 41'(diff);
        prod = (128'(dmag) * 128'(revs)) >> 16;
        pos = clip32(prod, diff < 0, sat);
        if (len == 0) begin
            vel = '0;
            at = 1'b1;
        end else begin
            at = 1'b0;
            n = wx * ex + wz * ez;
            neg = n < 0;
            nmag = neg ? 128'(-n) : 128'(n);
            prod = (nmag * 128'(revs)) / (128'(len) << 16);
            vel = clip32(prod, neg, sat);
        end
    endfunction

    function automatic t_out motor_command(input t_in s);
        t_out o;
        logic sat;
        sat = 1'b0;
        solve_pulley($signed({s.pos_x[31], s.pos_x}) - $signed({anc_ax[31], anc_ax}),
                     $signed({s.pos_z[31], s.pos_z}) - $signed({anc_az[31], anc_az}),
                     s.vel_x, s.vel_z, o.motor_a_position, o.motor_a_velocity,
                     o.at_anchor_a, sat);
        solve_pulley($signed({s.pos_x[31], s.pos_x}) - $signed({anc_bx[31], anc_bx}),
                     $signed({s.pos_z[31], s.pos_z}) - $signed({anc_bz[31], anc_bz}),
                     s.vel_x, s.vel_z, o.motor_b_position, o.motor_b_velocity,
                     o.at_anchor_b, sat);
        o.saturated = sat;
        return o;
    endfunction

    // Sender: bursts of random length, random gaps, payload held while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) motor_cmds.push_back(motor_command(i_data));
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (setpoints.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data  <= setpoints.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between none, light and heavy.
    always @(posedge i_clk) begin
        cyc++;
        if (cyc % 300 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 3);
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
        if (i_rst_n && o_valid && !i_stall) begin
            if (motor_cmds.size() == 0) begin
                $display("%0t unexpected beat: got %p", $time, o_data);
                errors++;
            end else begin
                t_out e;
                e = motor_cmds.pop_front();
                if (o_data !== e) begin
                    $display("%0t mismatch: expected %p", $time, e);
                    $display("%0t           actual   %p", $time, o_data);
                    errors++;
                end
            end
        end
    end

    // Blocking register write; mirror updated when the beat is taken.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ANCHOR_A_X:  anc_ax = val;
            CFG_ANCHOR_A_Z:  anc_az = val;
            CFG_ANCHOR_B_X:  anc_bx = val;
            CFG_ANCHOR_B_Z:  anc_bz = val;
            CFG_WIRE_LENGTH: wire_len = val[30:0];
            CFG_REV_SCALE:   revs = val[30:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_cfg_valid <= 1'b0;
        while (setpoints.size() > 0 || i_valid || motor_cmds.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_in sp(input logic [31:0] px, pz, vx, vz);
        t_in s;
        s.pos_x = px;
        s.pos_z = pz;
        s.vel_x = vx;
        s.vel_z = vz;
        return s;
    endfunction

    // Mostly modest setpoints near anchor A, some full-range noise, some on an anchor.
    function automatic t_in random_setpoint();
        t_in s;
        int k;
        k = $urandom_range(0, 9);
        s = sp($urandom, $urandom, $urandom, $urandom);
        if (k < 6) begin
            s.pos_x = anc_ax + $signed(32'($urandom_range(0, 32'h000A_0000))) - 32'sh5_0000;
            s.pos_z = anc_az + $signed(32'($urandom_range(0, 32'h000A_0000))) - 32'sh5_0000;
            s.vel_x = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh2_0000;
            s.vel_z = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh2_0000;
        end else if (k == 6) begin
            s.pos_x = anc_ax;
            s.pos_z = anc_az;
        end else if (k == 7) begin
            s.pos_x = anc_bx;
            s.pos_z = anc_bz;
        end
        return s;
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at reset settings: both anchors at the origin.
        setpoints.push_back(sp(0, 0, 0, 0));
        setpoints.push_back(sp(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        setpoints.push_back(sp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        setpoints.push_back(sp(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        setpoints.push_back(sp(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000));
        setpoints.push_back(sp(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
        drain();

        // Directed: distinct anchors, point on each, extreme scale and length.
        reg_write(CFG_ANCHOR_A_X, 32'hFFFE_0000);
        reg_write(CFG_ANCHOR_A_Z, 32'h0003_0000);
        reg_write(CFG_ANCHOR_B_X, 32'h0002_0000);
        reg_write(CFG_ANCHOR_B_Z, 32'h0003_0000);
        reg_write(CFG_WIRE_LENGTH, 32'h0008_0000);
        reg_write(CFG_REV_SCALE, 32'h0002_8BE6);
        reg_write(3'd6, 32'hDEAD_BEEF);
        reg_write(3'd7, 32'h1234_5678);
        setpoints.push_back(sp(32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000));
        setpoints.push_back(sp(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_0000));
        setpoints.push_back(sp(0, 0, 32'h0001_0000, 32'h0000_8000));
        setpoints.push_back(sp(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        drain();
        reg_write(CFG_WIRE_LENGTH, 32'h7FFF_FFFF);
        reg_write(CFG_REV_SCALE, 32'h7FFF_FFFF);
        setpoints.push_back(sp(0, 0, 32'h0001_0000, 32'h0001_0000));
        setpoints.push_back(sp(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        setpoints.push_back(sp(32'hFFFE_0000, 32'h0003_0000, 0, 0));
        drain();
        reg_write(CFG_REV_SCALE, 32'h0000_0000);
        setpoints.push_back(sp(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain();
        reg_write(CFG_ANCHOR_A_X, 32'h7FFF_FFFF);
        reg_write(CFG_ANCHOR_A_Z, 32'h8000_0000);
        reg_write(CFG_ANCHOR_B_X, 32'h8000_0000);
        reg_write(CFG_ANCHOR_B_Z, 32'h7FFF_FFFF);
        reg_write(CFG_REV_SCALE, 32'h0001_0000);
        setpoints.push_back(sp(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        setpoints.push_back(sp(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain();

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 0) begin
                reg_write(CFG_ANCHOR_A_X, $urandom);
                reg_write(CFG_ANCHOR_A_Z, $urandom);
                reg_write(CFG_ANCHOR_B_X, $urandom);
                reg_write(CFG_ANCHOR_B_Z, $urandom);
                reg_write(CFG_WIRE_LENGTH, $urandom);
                reg_write(CFG_REV_SCALE, $urandom);
            end else begin
                reg_write(CFG_ANCHOR_A_X, $urandom_range(0, 32'h000A_0000) - 32'h5_0000);
                reg_write(CFG_ANCHOR_A_Z, $urandom_range(0, 32'h000A_0000));
                reg_write(CFG_ANCHOR_B_X, $urandom_range(0, 32'h000A_0000));
                reg_write(CFG_ANCHOR_B_Z, $urandom_range(0, 32'h000A_0000));
                reg_write(CFG_WIRE_LENGTH, $urandom_range(0, 32'h0020_0000));
                reg_write(CFG_REV_SCALE, $urandom_range(32'h0000_1000, 32'h0008_0000));
            end
            for (int i = 0; i < 100; i++) setpoints.push_back(random_setpoint());
            drain();
        end

        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
